### rtl/dspr_pkg.sv
// Shared types, widths and constants for the daily schedule PWM ramp block.
// No dependencies; every other rtl file except dspr_ram imports this package.
package dspr_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int CFG_W   = 5;
  localparam int TIME_W  = 17;
  localparam int LEVEL_W = 8;
  localparam int PIDX_W  = 4;
  localparam int DUTY_W  = 7;
  localparam int WORD_W  = TIME_W + LEVEL_W;

  // Ramp arithmetic
  localparam int VAL_W  = 28;
  localparam int TGT_W  = 24;
  localparam int STEP_W = 26;
  localparam int GAP_W  = 19;

  localparam int DAY_SECONDS = 86400;
  localparam int FIX_SCALE   = 100000;
  localparam int FULL_DUTY   = 100;
  localparam int TARGET_MAX  = FIX_SCALE * FULL_DUTY;
  localparam int DUTY_LIMIT  = FIX_SCALE * (FULL_DUTY + 1);

  // Reciprocal of FIX_SCALE: exact floor for values below DUTY_LIMIT
  localparam int              RECIP_W  = 24;
  localparam int              RECIP_SH = 40;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd10995117;

  // Serial divider
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 18;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // Small queues
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic {
    OP_TICK,
    OP_WRITE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic                wr_ok;
    logic [TIME_W-1:0]   tod;
    logic [PIDX_W-1:0]   idx;
    logic [TIME_W-1:0]   etime;
    logic [LEVEL_W-1:0]  elevel;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              duty_changed;
    logic              event_fired;
    logic [PIDX_W-1:0] fired_index;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIRE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RAMP,
    ST_DUTY_GO,
    ST_DUTY_MUL,
    ST_FINISH
  } state_e;

endpackage

### rtl/dspr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/dspr_front.sv
// Front end: accepts input items, classifies them and holds them in a short queue.
// Depends on dspr_pkg.
module dspr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         cmd_i,
  input  logic [dspr_pkg::TIME_W-1:0]  time_of_day_i,
  input  logic [dspr_pkg::PIDX_W-1:0]  entry_index_i,
  input  logic [dspr_pkg::TIME_W-1:0]  entry_time_i,
  input  logic [dspr_pkg::LEVEL_W-1:0] entry_level_i,
  output logic                         item_valid_o,
  output dspr_pkg::item_t              item_o,
  input  logic                         item_pop_i
);
  import dspr_pkg::*;

  item_t             q_mem [QDEPTH];
  item_t             item_d;
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  // classify
  always_comb begin
    item_d.op     = (cmd_i == CMD_WRITE) ? OP_WRITE : OP_TICK;
    item_d.wr_ok  = 32'(entry_index_i) < MAX_ENTRIES;
    item_d.tod    = time_of_day_i;
    item_d.idx    = entry_index_i;
    item_d.etime  = entry_time_i;
    item_d.elevel = entry_level_i;
  end

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wptr_q] <= item_d;
    end
  end

endmodule

### rtl/dspr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dspr_pkg.
module dspr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dspr_pkg::div_req_t req_i,
  output dspr_pkg::div_rsp_t rsp_o
);
  import dspr_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && cnt_q == '0) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
      cnt_q <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### rtl/dspr_back.sv
// Back end: table store, event scan sequencer, ramp update and result queue.
// Depends on dspr_pkg and dspr_ram; drives the dspr_div unit.
module dspr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dspr_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       item_valid_i,
  input  dspr_pkg::item_t            item_i,
  output logic                       item_pop_o,
  output dspr_pkg::div_req_t         div_req_o,
  input  dspr_pkg::div_rsp_t         div_rsp_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output dspr_pkg::result_t          result_o
);
  import dspr_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]       cfg_count_q;
  logic [CNT_W-1:0]       n_eff;
  logic [IDX_W-1:0]       last_idx;
  logic [MAX_ENTRIES-1:0] taken_q;

  // table RAM
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_rdata;

  // scan
  logic [TIME_W-1:0]  now_q;
  logic [CNT_W-1:0]   k_q;
  logic [TIME_W-1:0]  prev_t_q, first_t_q, nxt_t_q;
  logic [LEVEL_W-1:0] prev_l_q, first_l_q, nxt_l_q, lvl_q;
  logic [IDX_W-1:0]   fire_idx_q;
  logic               fired_q;
  logic [TIME_W-1:0]  cur_t;
  logic [LEVEL_W-1:0] cur_l;
  logic [IDX_W-1:0]   jdx, pjdx;
  logic               win_hit, final_hit, is_last, data_ok;
  logic               scan_fire, scan_done;
  logic [IDX_W-1:0]   fire_idx_d, clr_idx;
  logic               clr_en;
  logic [TIME_W-1:0]  nxt_t_d;
  logic [LEVEL_W-1:0] nxt_l_d, lvl_d;

  // event setup
  logic [LEVEL_W-1:0]      absdiff;
  logic                    neg_d, neg_q;
  logic [DIV_NUM_W-1:0]    num_d, num_q;
  logic signed [GAP_W-1:0] now_s, nt_s, gap_raw;
  logic [DIV_DEN_W-1:0]    den_d, den_q;
  logic [DUTY_W-1:0]       cap;
  logic [TGT_W-1:0]        tgt_d;
  logic [STEP_W-1:0]       step_mag;

  // ramp
  logic signed [VAL_W-1:0]  ramp_value_q;
  logic [TGT_W-1:0]         ramp_target_q;
  logic signed [STEP_W-1:0] ramp_step_q;
  logic signed [VAL_W-1:0]  tgt_s, sat, v_new;
  logic signed [VAL_W:0]    sum_w;
  logic                     below, on_target, val_neg, val_high;
  logic [2*RECIP_W-1:0]     prod_q;
  logic [DUTY_W-1:0]        duty_new_q, last_duty_q;

  // result queue
  result_t           res_mem [QDEPTH];
  result_t           res_d;
  logic [QPTR_W-1:0] res_wptr_q, res_rptr_q;
  logic [QCNT_W-1:0] res_cnt_q;
  logic              res_full, res_push, res_pop;

  assign n_eff    = (32'(cfg_count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                      : CNT_W'(cfg_count_q);
  assign last_idx = IDX_W'(n_eff - CNT_W'(1));

  assign ram_waddr = IDX_W'(item_i.idx);

  dspr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({item_i.etime, item_i.elevel}),
    .re_i    (ram_re),
    .raddr_i (k_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---- scan decision: data of entry k-1 is on the RAM output ----
  assign cur_t   = ram_rdata[WORD_W-1:LEVEL_W];
  assign cur_l   = ram_rdata[LEVEL_W-1:0];
  assign jdx     = IDX_W'(k_q - CNT_W'(1));
  assign pjdx    = jdx - IDX_W'(1);
  assign data_ok = (k_q != '0);
  assign is_last = (jdx == last_idx);

  assign win_hit   = (k_q >= CNT_W'(2)) && (now_q >= prev_t_q) && (now_q < cur_t) &&
                     !taken_q[pjdx];
  assign final_hit = is_last && (now_q >= cur_t) && !taken_q[jdx];
  assign scan_fire = data_ok && (win_hit || final_hit);
  assign scan_done = data_ok && is_last;

  always_comb begin
    if (win_hit) begin
      fire_idx_d = pjdx;
      clr_en     = 1'b1;
      clr_idx    = (pjdx == '0) ? last_idx : pjdx - IDX_W'(1);
      lvl_d      = prev_l_q;
      nxt_t_d    = cur_t;
      nxt_l_d    = cur_l;
    end else begin
      // last entry ramps toward entry 0; a lone entry ramps toward itself
      fire_idx_d = jdx;
      clr_en     = (last_idx != '0);
      clr_idx    = last_idx - IDX_W'(1);
      lvl_d      = cur_l;
      nxt_t_d    = (jdx == '0) ? cur_t : first_t_q;
      nxt_l_d    = (jdx == '0) ? cur_l : first_l_q;
    end
  end

  // ---- event setup ----
  assign neg_d   = (nxt_l_q < lvl_q);
  assign absdiff = neg_d ? (lvl_q - nxt_l_q) : (nxt_l_q - lvl_q);
  assign num_d   = DIV_NUM_W'(absdiff) * DIV_NUM_W'(FIX_SCALE);

  assign now_s   = $signed(GAP_W'(now_q));
  assign nt_s    = $signed(GAP_W'(nxt_t_q));
  assign gap_raw = (now_q <= nxt_t_q) ? (nt_s - now_s)
                                      : ($signed(GAP_W'(DAY_SECONDS)) - now_s + nt_s);
  assign den_d   = (!gap_raw[GAP_W-1] && gap_raw != '0) ? DIV_DEN_W'(gap_raw)
                                                         : DIV_DEN_W'(DAY_SECONDS);

  assign cap      = (nxt_l_q > LEVEL_W'(FULL_DUTY)) ? DUTY_W'(FULL_DUTY)
                                                    : nxt_l_q[DUTY_W-1:0];
  assign tgt_d    = TGT_W'(cap) * TGT_W'(FIX_SCALE);
  assign step_mag = STEP_W'(div_rsp_i.quo);

  // ---- ramp step with saturation and clamp to target ----
  assign tgt_s     = $signed({{(VAL_W - TGT_W){1'b0}}, ramp_target_q});
  assign sum_w     = (VAL_W + 1)'(ramp_value_q) + (VAL_W + 1)'(ramp_step_q);
  assign below     = (ramp_value_q < tgt_s);
  assign on_target = (ramp_value_q == tgt_s);

  always_comb begin
    if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
      sat = sum_w[VAL_W] ? {1'b1, {(VAL_W - 1){1'b0}}} : {1'b0, {(VAL_W - 1){1'b1}}};
    end else begin
      sat = sum_w[VAL_W-1:0];
    end
    if (below) begin
      v_new = (sat > tgt_s) ? tgt_s : sat;
    end else begin
      v_new = (sat < tgt_s) ? tgt_s : sat;
    end
  end

  assign val_neg  = ramp_value_q[VAL_W-1];
  assign val_high = (ramp_value_q >= $signed(VAL_W'(DUTY_LIMIT)));

  // ---- result queue ----
  assign res_full = (res_cnt_q == QCNT_W'(QDEPTH));
  assign empty_o  = (res_cnt_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign result_o = res_mem[res_rptr_q];

  always_comb begin
    res_d.duty         = duty_new_q;
    res_d.duty_changed = (duty_new_q != last_duty_q);
    res_d.event_fired  = fired_q;
    res_d.fired_index  = PIDX_W'(fire_idx_q);
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && item_i.op == OP_TICK) begin
          state_d = (n_eff == '0) ? ST_RAMP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_fire) begin
          state_d = ST_FIRE;
        end else if (scan_done) begin
          state_d = ST_RAMP;
        end
      end
      ST_FIRE:     state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = ST_RAMP;
        end
      end
      ST_RAMP:     state_d = on_target ? ST_FINISH : ST_DUTY_GO;
      ST_DUTY_GO:  state_d = (val_neg || val_high) ? ST_FINISH : ST_DUTY_MUL;
      ST_DUTY_MUL: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!res_full) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer: strobes ----
  always_comb begin
    item_pop_o      = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    res_push        = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = num_q;
    div_req_o.den   = den_q;
    case (state_q)
      ST_IDLE: begin
        item_pop_o = item_valid_i;
        ram_we     = item_valid_i && item_i.op == OP_WRITE && item_i.wr_ok;
      end
      ST_SCAN:   ram_re = (k_q < n_eff);
      ST_DIV_GO: div_req_o.start = 1'b1;
      ST_FINISH: res_push = !res_full;
      default: ;
    endcase
  end

  // ---- state with reset ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cfg_count_q   <= '0;
      taken_q       <= '0;
      ramp_value_q  <= '0;
      ramp_target_q <= '0;
      ramp_step_q   <= '0;
      last_duty_q   <= '0;
      res_wptr_q    <= '0;
      res_rptr_q    <= '0;
      res_cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_count_q <= cfg_data_i;
      end
      if (ram_we) begin
        taken_q[ram_waddr] <= 1'b0;
      end
      if (state_q == ST_SCAN && scan_fire) begin
        taken_q[fire_idx_d] <= 1'b1;
        if (clr_en) begin
          taken_q[clr_idx] <= 1'b0;
        end
      end
      if (state_q == ST_FIRE) begin
        ramp_value_q  <= $signed(VAL_W'(ramp_target_q));
        ramp_target_q <= tgt_d;
      end
      if (state_q == ST_DIV_WAIT && div_rsp_i.done) begin
        ramp_step_q <= neg_q ? -$signed(step_mag) : $signed(step_mag);
      end
      if (state_q == ST_RAMP && !on_target) begin
        ramp_value_q <= v_new;
      end
      if (res_push) begin
        last_duty_q <= duty_new_q;
        res_wptr_q  <= (res_wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_wptr_q + QPTR_W'(1);
      end
      if (res_pop) begin
        res_rptr_q <= (res_rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : res_rptr_q + QPTR_W'(1);
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + QCNT_W'(1);
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - QCNT_W'(1);
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_pop_o) begin
          now_q      <= item_i.tod;
          k_q        <= '0;
          fired_q    <= 1'b0;
          fire_idx_q <= '0;
        end
      end
      ST_SCAN: begin
        k_q      <= k_q + CNT_W'(1);
        prev_t_q <= cur_t;
        prev_l_q <= cur_l;
        if (k_q == CNT_W'(1)) begin
          first_t_q <= cur_t;
          first_l_q <= cur_l;
        end
        if (scan_fire) begin
          fired_q    <= 1'b1;
          fire_idx_q <= fire_idx_d;
          lvl_q      <= lvl_d;
          nxt_t_q    <= nxt_t_d;
          nxt_l_q    <= nxt_l_d;
        end
      end
      ST_FIRE: begin
        num_q <= num_d;
        den_q <= den_d;
        neg_q <= neg_d;
      end
      ST_RAMP: begin
        if (on_target) begin
          duty_new_q <= last_duty_q;
        end
      end
      ST_DUTY_GO: begin
        prod_q <= ramp_value_q[RECIP_W-1:0] * RECIP_M;
        if (val_neg) begin
          duty_new_q <= '0;
        end else if (val_high) begin
          duty_new_q <= DUTY_W'(FULL_DUTY);
        end
      end
      ST_DUTY_MUL: duty_new_q <= prod_q[RECIP_SH+DUTY_W-1:RECIP_SH];
      default: ;
    endcase
    if (res_push) begin
      res_mem[res_wptr_q] <= res_d;
    end
  end

  // ---- assertions ----
  a_fired_marked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && fired_q) |-> taken_q[fire_idx_q])
    else $error("reported event is not marked taken");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("divider started while busy");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && item_i.op == OP_WRITE) |=> (state_q == ST_IDLE))
    else $error("write item left the idle state");

  a_duty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (duty_new_q <= DUTY_W'(FULL_DUTY)))
    else $error("duty above full scale");

  a_target_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE) |=> (ramp_target_q <= TGT_W'(TARGET_MAX)))
    else $error("ramp target above cap");

endmodule

### rtl/daily_schedule_pwm_ramp_top.sv
// Top level of the daily schedule PWM ramp block.
// Depends on dspr_pkg, dspr_front, dspr_div, dspr_back (and dspr_ram below it).
//
// One dimmer channel driven by a table of up to MAX_ENTRIES daily events. Items
// enter through a queue-style port (push/full) and results leave through one
// (empty/pop). A write item (cmd_i = 1) loads one table slot with an event
// time and level and clears its taken mark; it produces no result. A tick item
// (cmd_i = 0) carries the time of day, fires the first untaken event whose
// window is reached, moves the ramp one step toward its target and produces one
// result: the duty 0..100, whether it changed, whether an event fired and its
// index. Set event_count through cfg_we_i/cfg_data_i only while the block
// is idle; the block does not enforce this. Zero disables events. In the back end
// a tick reads one table entry per cycle of the n entries in use, stopping at the
// firing entry; an event adds a run of the bit-serial 25-bit step divider, and the
// duty itself comes from a registered reciprocal multiply. Two-entry queues on
// either side let a new item be taken while a result waits to be popped.
module daily_schedule_pwm_ramp_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item transfer
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd_i,
  input  logic [dspr_pkg::TIME_W-1:0]  time_of_day_i,
  input  logic [dspr_pkg::PIDX_W-1:0]  entry_index_i,
  input  logic [dspr_pkg::TIME_W-1:0]  entry_time_i,
  input  logic [dspr_pkg::LEVEL_W-1:0] entry_level_i,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [dspr_pkg::CFG_W-1:0]   cfg_data_i,
  // result transfer
  output logic                         empty,
  input  logic                         pop,
  output logic [dspr_pkg::DUTY_W-1:0]  duty_o,
  output logic                         duty_changed_o,
  output logic                         event_fired_o,
  output logic [dspr_pkg::PIDX_W-1:0]  fired_index_o
);
  import dspr_pkg::*;

  item_t    item;
  logic     item_valid;
  logic     item_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  result;

  // front: classify and queue incoming items
  dspr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cmd_i         (cmd_i),
    .time_of_day_i (time_of_day_i),
    .entry_index_i (entry_index_i),
    .entry_time_i  (entry_time_i),
    .entry_level_i (entry_level_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  // serial divider for the per-second ramp step
  dspr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // back: table, scan, ramp and result queue
  dspr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result)
  );

  assign duty_o         = result.duty;
  assign duty_changed_o = result.duty_changed;
  assign event_fired_o  = result.event_fired;
  assign fired_index_o  = result.fired_index;

endmodule

### bench/tb_top.sv
// Self-checking bench for daily_schedule_pwm_ramp_top: drives schedule writes and
// time ticks, predicts every result in a scoreboard class, checks each popped result.
// Depends on rtl/dspr_pkg.sv and the block's rtl files.
`timescale 1ns / 100ps

module tb_top;
  import dspr_pkg::*;

  // ramp accumulator is a signed VAL_W-bit value that saturates
  localparam longint RAMP_MAX = (longint'(1) << (VAL_W - 1)) - 1;
  localparam longint RAMP_MIN = -(longint'(1) << (VAL_W - 1));

  localparam int CYCLE_LIMIT   = 1_000_000;
  // a tick with an event also runs the serial divider; queues hold QDEPTH items each
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 600;
  localparam int ITEM_TARGET   = 1250;
  localparam int TIME_TOP      = (1 << TIME_W) - 1;
  localparam int CFG_TOP       = (1 << CFG_W) - 1;

  // Scoreboard: keeps its own copy of the table and the ramp, predicts one
  // result per tick transfer and compares popped results in order.
  class dimmer_checker;
    logic [TIME_W-1:0]  ev_time  [MAX_ENTRIES];
    logic [LEVEL_W-1:0] ev_level [MAX_ENTRIES];
    bit                 ev_taken [MAX_ENTRIES];
    longint             ramp_val;
    longint             ramp_tgt;
    longint             ramp_stp;
    logic [DUTY_W-1:0]  last_duty;
    logic [CFG_W-1:0]   entries_used;
    result_t            pending_duty [$];
    int unsigned        mismatches;

    function new();
      foreach (ev_time[k]) begin
        ev_time[k]  = '0;
        ev_level[k] = '0;
        ev_taken[k] = 1'b0;
      end
      ramp_val     = 0;
      ramp_tgt     = 0;
      ramp_stp     = 0;
      last_duty    = '0;
      entries_used = '0;
      mismatches   = 0;
    endfunction

    function void set_entries(logic [CFG_W-1:0] v);
      entries_used = v;
    endfunction

    function int outstanding();
      return pending_duty.size();
    endfunction

    function longint clip_ramp(longint v);
      if (v > RAMP_MAX) return RAMP_MAX;
      if (v < RAMP_MIN) return RAMP_MIN;
      return v;
    endfunction

    // event taken: snap to the old target, aim at the next entry's level
    function void start_ramp(longint now, longint lvl, longint next_t, longint next_l);
      longint gap;
      longint tgt;
      if (now <= next_t) gap = next_t - now;
      else gap = (DAY_SECONDS - now) + next_t;
      if (gap <= 0) gap = DAY_SECONDS;
      ramp_stp = ((next_l - lvl) * FIX_SCALE) / gap;
      ramp_val = ramp_tgt;
      tgt = next_l * FIX_SCALE;
      if (tgt > TARGET_MAX) tgt = TARGET_MAX;
      ramp_tgt = tgt;
    endfunction

    function bit scan_table(longint now, output logic [PIDX_W-1:0] hit);
      int n;
      int last;
      hit = '0;
      n = (entries_used > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_used);
      if (n == 0) return 1'b0;
      last = n - 1;
      for (int i = 0; i < last; i++) begin
        if (now >= longint'(ev_time[i]) && now < longint'(ev_time[i+1]) && !ev_taken[i]) begin
          ev_taken[i] = 1'b1;
          if (i > 0) ev_taken[i-1] = 1'b0;
          else ev_taken[last] = 1'b0;
          start_ramp(now, longint'(ev_level[i]), longint'(ev_time[i+1]),
                     longint'(ev_level[i+1]));
          hit = PIDX_W'(i);
          return 1'b1;
        end
      end
      if (now >= longint'(ev_time[last]) && !ev_taken[last]) begin
        ev_taken[last] = 1'b1;
        if (last > 0) ev_taken[last-1] = 1'b0;
        start_ramp(now, longint'(ev_level[last]), longint'(ev_time[0]),
                   longint'(ev_level[0]));
        hit = PIDX_W'(last);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit step_ramp();
      longint d;
      if (ramp_val == ramp_tgt) return 1'b0;
      if (ramp_val < ramp_tgt) begin
        ramp_val = clip_ramp(ramp_val + ramp_stp);
        if (ramp_val > ramp_tgt) ramp_val = ramp_tgt;
      end
      if (ramp_val > ramp_tgt) begin
        ramp_val = clip_ramp(ramp_val + ramp_stp);
        if (ramp_val < ramp_tgt) ramp_val = ramp_tgt;
      end
      d = ramp_val / FIX_SCALE;
      if (d > FULL_DUTY) d = FULL_DUTY;
      if (d < 0) d = 0;
      if (d == longint'(last_duty)) return 1'b0;
      last_duty = DUTY_W'(d);
      return 1'b1;
    endfunction

    // called once per accepted input transfer, in transfer order
    function void apply_item(logic c, logic [TIME_W-1:0] tod, logic [PIDX_W-1:0] slot,
                             logic [TIME_W-1:0] et, logic [LEVEL_W-1:0] el);
      result_t          r;
      logic [PIDX_W-1:0] hit;
      bit               fired;
      bit               chg;
      if (c == OP_WRITE) begin
        if (slot < MAX_ENTRIES) begin
          ev_time[slot]  = et;
          ev_level[slot] = el;
          ev_taken[slot] = 1'b0;
        end
        return;
      end
      fired = scan_table(longint'(tod), hit);
      chg = step_ramp();
      r.duty         = last_duty;
      r.duty_changed = chg;
      r.event_fired  = fired;
      r.fired_index  = fired ? hit : '0;
      pending_duty.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_duty(logic [DUTY_W-1:0] d, logic chg, logic fired, logic [PIDX_W-1:0] fidx);
      result_t e;
      if (pending_duty.size() == 0) begin
        report_mismatch("result popped with no tick waiting");
        return;
      end
      e = pending_duty.pop_front();
      if (d !== e.duty)
        report_mismatch($sformatf("duty %0d, expected %0d", d, e.duty));
      if (chg !== e.duty_changed)
        report_mismatch($sformatf("duty_changed %b, expected %b", chg, e.duty_changed));
      if (fired !== e.event_fired)
        report_mismatch($sformatf("event_fired %b, expected %b", fired, e.event_fired));
      if (fidx !== e.fired_index)
        report_mismatch($sformatf("fired_index %0d, expected %0d", fidx, e.fired_index));
    endtask
  endclass

  // All block inputs start at known values; reset is held from time zero.
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  logic               cmd         = 1'b0;
  logic [TIME_W-1:0]  time_of_day = '0;
  logic [PIDX_W-1:0]  entry_index = '0;
  logic [TIME_W-1:0]  entry_time  = '0;
  logic [LEVEL_W-1:0] entry_level = '0;
  logic               cfg_we      = 1'b0;
  logic [CFG_W-1:0]   cfg_data    = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [DUTY_W-1:0]  duty;
  logic               duty_changed;
  logic               event_fired;
  logic [PIDX_W-1:0]  fired_index;

  dimmer_checker dimmer_sb = new();

  // sender state shared by the driving tasks
  int  items_sent = 0;
  int  burst_left = 0;
  bit  gaps_on    = 1'b1;
  int  tb_times [MAX_ENTRIES];

  // receiver state; the long hold is requested by the stimulus, counted here
  bit  long_hold_req  = 1'b0;
  bit  long_hold_done = 1'b0;
  int  hold_cnt       = 0;
  int  stall_left     = 0;
  int  seg_left       = 0;
  int  rx_mode        = 0;
  int  cycles         = 0;

  daily_schedule_pwm_ramp_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd),
    .time_of_day_i  (time_of_day),
    .entry_index_i  (entry_index),
    .entry_time_i   (entry_time),
    .entry_level_i  (entry_level),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .duty_o         (duty),
    .duty_changed_o (duty_changed),
    .event_fired_o  (event_fired),
    .fired_index_o  (fired_index)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver. Values read right after the edge are the pre-edge ones, so a
  // result transfer happened when pop was high and empty low. The stall mode
  // changes whenever its segment counter runs out: always ready, short stalls, long stalls.
  always @(posedge clk) begin
    if (pop && !empty)
      dimmer_sb.check_duty(duty, duty_changed, event_fired, fired_index);
    if (seg_left == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      seg_left <= $urandom_range(50, 300);
    end else begin
      seg_left <= seg_left - 1;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      // long hold-off: block fills up and must stall its input
      pop <= 1'b0;
      if (hold_cnt == LONG_HOLD) long_hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      case (rx_mode)
        1: begin
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
        end
        2: begin
          if ($urandom_range(0, 1) == 1) stall_left <= $urandom_range(1, 20);
        end
        default: ;
      endcase
    end
  end

  // One input transfer. Bursts of random length, random gaps between them;
  // payload is scrambled while push is low so idle values must be ignored.
  task automatic offer(logic c, logic [TIME_W-1:0] tod, logic [PIDX_W-1:0] slot,
                       logic [TIME_W-1:0] et, logic [LEVEL_W-1:0] el);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 30);
      push        <= 1'b0;
      cmd         <= 1'($urandom);
      time_of_day <= TIME_W'($urandom);
      entry_index <= PIDX_W'($urandom);
      entry_time  <= TIME_W'($urandom);
      entry_level <= LEVEL_W'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    push        <= 1'b1;
    cmd         <= c;
    time_of_day <= tod;
    entry_index <= slot;
    entry_time  <= et;
    entry_level <= el;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    dimmer_sb.apply_item(c, tod, slot, et, el);
    items_sent++;
  endtask

  // tick: only time_of_day matters, the entry fields carry noise
  task automatic tick(int tod);
    offer(OP_TICK, TIME_W'(tod), PIDX_W'($urandom), TIME_W'($urandom), LEVEL_W'($urandom));
  endtask

  task automatic write_entry(int slot, int t, int l);
    tb_times[slot] = t;
    offer(OP_WRITE, TIME_W'($urandom), PIDX_W'(slot), TIME_W'(t), LEVEL_W'(l));
  endtask

  // Stop sending until every predicted result has been popped, then let the
  // back end finish any queued table writes.
  task automatic drain(int settle);
    push <= 1'b0;
    @(posedge clk);
    while (dimmer_sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_entries(int cnt);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(cnt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    dimmer_sb.set_entries(CFG_W'(cnt));
  endtask

  // Well-formed day: sorted event table, then ticks that creep forward a few
  // seconds or jump onto an event time, wrapping past midnight. A few stray
  // writes re-arm entries, a few ticks lie beyond the end of the day.
  task automatic sweep_phase(int n_eff, int len, bit pause_mid);
    int nw;
    int cur;
    int r;
    int tq [$];
    nw = (n_eff == 0) ? $urandom_range(1, 4) : n_eff;
    for (int k = 0; k < nw; k++)
      tq.push_back(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, DAY_SECONDS));
    tq.sort();
    for (int k = 0; k < nw; k++)
      write_entry(k, tq[k],
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, FULL_DUTY));
    cur = $urandom_range(0, DAY_SECONDS);
    for (int k = nw; k < len; k++) begin
      if (pause_mid && k == len / 2) drain(0);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        write_entry($urandom_range(0, MAX_ENTRIES - 1), $urandom_range(0, DAY_SECONDS),
                    $urandom_range(0, 255));
      end else if (r == 1) begin
        tick($urandom_range(DAY_SECONDS + 1, TIME_TOP));
      end else begin
        if (r < 11) cur += $urandom_range(1, 3);
        else cur = tb_times[$urandom_range(0, nw - 1)] + $urandom_range(0, 2);
        if (cur > DAY_SECONDS) cur -= DAY_SECONDS;
        tick(cur);
      end
    end
  endtask

  // Unstructured traffic: writes anywhere, ticks at any time of day.
  task automatic noise_phase(int len);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 2) == 0)
        write_entry($urandom_range(0, MAX_ENTRIES - 1), $urandom_range(0, DAY_SECONDS),
                    $urandom_range(0, 255));
      else if ($urandom_range(0, 15) == 0)
        tick($urandom_range(DAY_SECONDS + 1, TIME_TOP));
      else
        tick($urandom_range(0, DAY_SECONDS));
    end
  endtask

  initial begin : stimulus
    int phase;
    int cnt;
    int r;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // --- directed part ---
    // events disabled: ticks just report the idle duty
    tick(0);
    tick(DAY_SECONDS);
    // small table: upward ramp with a level above the cap, a downward ramp,
    // last entry at the end of the day
    write_entry(0, 1, 0);
    write_entry(1, 100, 255);
    write_entry(2, 65535, 100);
    write_entry(3, DAY_SECONDS, 50);
    drain(SETTLE_CYCLES);
    set_entries(4);
    tick(0);            // before the first event
    tick(50);           // entry 0 fires, ramps up
    tick(51);           // already taken, ramp keeps moving
    tick(70000);        // entry 2, ramp down
    tick(TIME_TOP);     // beyond the day: last entry fires, gap goes negative
    tick(DAY_SECONDS);  // nothing left to fire
    // zero event time on the last entry: its window is always reached, and
    // with two windows open only the lower index fires
    write_entry(3, 0, 50);
    tick(120);
    tick(121);
    // one-entry table, tick right on the event time: zero gap
    drain(SETTLE_CYCLES);
    set_entries(1);
    tick(1);
    tick(2);

    // --- random part ---
    // phase 0 loads the whole table with a count above the table size, so
    // no later tick ever reads a slot that was never written
    while (items_sent < ITEM_TARGET) begin
      drain(SETTLE_CYCLES);
      case (phase)
        0: cnt = CFG_TOP;
        1: cnt = 2;
        2: cnt = MAX_ENTRIES;
        3: cnt = 0;
        4: cnt = 1;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) cnt = 0;
          else if (r == 1) cnt = 1;
          else if (r == 2) cnt = MAX_ENTRIES;
          else if (r == 3) cnt = $urandom_range(MAX_ENTRIES + 1, CFG_TOP);
          else cnt = $urandom_range(2, MAX_ENTRIES - 1);
        end
      endcase
      set_entries(cnt);
      if (phase == 2) begin
        // receiver holds off while the sender pushes back to back
        long_hold_req <= 1'b1;
        gaps_on = 1'b0;
      end
      if (phase != 0 && (phase == 3 || $urandom_range(0, 4) == 0))
        noise_phase($urandom_range(60, 110));
      else
        sweep_phase((cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt, $urandom_range(60, 110), phase == 4);
      gaps_on = 1'b1;
      phase++;
    end

    drain(SETTLE_CYCLES);
    if (dimmer_sb.mismatches == 0 && dimmer_sb.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
